FILE: hdl/cad_pkg.sv
`default_nettype none
package cad_pkg;

	localparam int unsigned DayW   = 5;
	localparam int unsigned MonthW = 4;
	localparam int unsigned YearW  = 14;
	localparam int unsigned AddW   = 15;
	// day-of-year plus count stays below 2^16
	localparam int unsigned TotalW = 16;
	// walking year may pass the field width
	localparam int unsigned WalkYearW = YearW + 1;

	localparam logic [YearW-1:0] LeapCycle = YearW'(400);
	localparam logic [YearW-1:0] CycleLast = YearW'(399);
	localparam logic [YearW-1:0] Century1  = YearW'(100);
	localparam logic [YearW-1:0] Century2  = YearW'(200);
	localparam logic [YearW-1:0] Century3  = YearW'(300);

	localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
	localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
	localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

	localparam logic [DayW-1:0] FebLeapDays = DayW'(29);
	localparam logic [DayW-1:0] MonthLen [12] = '{
		DayW'(31), DayW'(28), DayW'(31), DayW'(30), DayW'(31), DayW'(30),
		DayW'(31), DayW'(31), DayW'(30), DayW'(31), DayW'(30), DayW'(31)
	};

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_DOY    = 4'b0100,
		ST_WALK   = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic reduce_step;
		logic doy_step;
		logic walk_init;
		logic walk_step;
	} cmd_t;

	typedef struct packed {
		logic reduce_done;
		logic doy_done;
		logic walk_done;
	} sts_t;

	// months outside 1..12 count as zero days
	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DayW-1:0] len;
		len = '0;
		if (m >= MonthJan && m <= MonthDec) begin
			if (m == MonthFeb && leap) begin
				len = FebLeapDays;
			end else begin
				len = MonthLen[m - MonthJan];
			end
		end
		return len;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/cad_ctrl.sv
`default_nettype none
module cad_ctrl
	import cad_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (sts.reduce_done) begin
					state_d = ST_DOY;
				end else begin
					cmd.reduce_step = 1'b1;
				end
			end
			ST_DOY: begin
				if (sts.doy_done) begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK;
				end else begin
					cmd.doy_step = 1'b1;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_IDLE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_WALK) && sts.walk_done;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

FILE: hdl/cad_dpath.sv
`default_nettype none
module cad_dpath
	import cad_pkg::*;
(
	input  wire                 clk,
	input  cmd_t                cmd,
	input  wire  [DayW-1:0]     start_day,
	input  wire  [MonthW-1:0]   start_month,
	input  wire  [YearW-1:0]    start_year,
	input  wire  [AddW-1:0]     days_to_add,
	output sts_t                sts,
	output logic [DayW-1:0]     new_day,
	output logic [MonthW-1:0]   new_month,
	output logic [YearW-1:0]    new_year
);

	logic [TotalW-1:0]    total_q;
	logic [MonthW-1:0]    mon_q;
	logic [MonthW-1:0]    m_q;
	logic [WalkYearW-1:0] year_q;
	// year modulo 400, tracked alongside the walking year
	logic [YearW-1:0]     cyc_q;
	logic                 leap;
	logic [DayW-1:0]      len;

	assign leap = (cyc_q[1:0] == 2'b00) && (cyc_q != Century1) &&
		(cyc_q != Century2) && (cyc_q != Century3);
	assign len  = month_days(m_q, leap);

	assign sts.reduce_done = (cyc_q < LeapCycle);
	assign sts.doy_done    = (m_q >= mon_q);
	assign sts.walk_done   = (total_q <= TotalW'(len));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			total_q <= TotalW'(start_day) + TotalW'(days_to_add);
			mon_q   <= start_month;
			m_q     <= MonthJan;
			year_q  <= WalkYearW'(start_year);
			cyc_q   <= start_year;
		end
		if (cmd.reduce_step) begin
			cyc_q <= cyc_q - LeapCycle;
		end
		if (cmd.doy_step) begin
			total_q <= total_q + TotalW'(len);
			m_q     <= m_q + MonthW'(1);
		end
		if (cmd.walk_init) begin
			m_q <= MonthJan;
		end
		if (cmd.walk_step) begin
			total_q <= total_q - TotalW'(len);
			if (m_q == MonthDec) begin
				// roll over to January of the next year
				m_q    <= MonthJan;
				year_q <= year_q + WalkYearW'(1);
				cyc_q  <= (cyc_q == CycleLast) ? '0 : cyc_q + YearW'(1);
			end else begin
				m_q <= m_q + MonthW'(1);
			end
		end
	end

	assign new_day   = total_q[DayW-1:0];
	assign new_month = m_q;
	assign new_year  = year_q[YearW-1:0];

endmodule
`default_nettype wire

FILE: hdl/calendar_add_days.sv
`default_nettype none
// Gregorian date plus a day count.
// Pulse start with start_day, start_month, start_year and days_to_add while
// busy is low; the fields are captured on that transfer and busy rises on the
// next cycle. One item is worked on at a time.
// The work runs in three phases, the last two on one shared month-length
// lookup, each phase testing its end condition before every step:
//   - reduce the year modulo 400 for the leap rule, one subtract per cycle,
//     at most 40 steps for years up to 16383;
//   - sum the months before the start month, one month per cycle, up to 14;
//   - walk month by month from January, one month per cycle, up to about
//     1090 steps for the largest count.
// done is registered from the end of the walk phase; the next start is taken
// in the cycle done is high.
// The result is on new_day, new_month and new_year in the cycle in which done
// is high and holds until the next start is taken; the receiver cannot stall
// it.
// Reset clears the controller to idle with busy and done low.
module calendar_add_days
	import cad_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [DayW-1:0]    start_day,
	input  wire  [MonthW-1:0]  start_month,
	input  wire  [YearW-1:0]   start_year,
	input  wire  [AddW-1:0]    days_to_add,
	output logic               done,
	output logic [DayW-1:0]    new_day,
	output logic [MonthW-1:0]  new_month,
	output logic [YearW-1:0]   new_year
);

	cmd_t cmd;
	sts_t sts;

	cad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cad_dpath u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.days_to_add (days_to_add),
		.sts         (sts),
		.new_day     (new_day),
		.new_month   (new_month),
		.new_year    (new_year)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted start did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (new_month >= MonthJan && new_month <= MonthDec))
		else $error("result month out of range");

endmodule
`default_nettype wire
